/* design/pfs_pkg.sv */
// Shared types, constants and the odd-factor inverse table for the SPF sieve factorizer.
package pfs_pkg;

    localparam int LIMIT_DEF = 65536;
    localparam int NUM_W     = 16;
    localparam int ENTRY_W   = 8;
    localparam int INV_N     = 128;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_SV_RDI,
        S_SV_CHKI,
        S_SV_RDJ,
        S_SV_CHKJ,
        S_IDLE,
        S_Q_RD,
        S_Q_LOOK,
        S_Q_DIV,
        S_Q_NONE
    } t_state;

    typedef enum logic [1:0] {
        DM_PRIME,
        DM_HALF,
        DM_ODD
    } t_dmode;

    typedef logic [INV_N-1:0][NUM_W-1:0] t_inv_tab;

    // Inverse of each odd value modulo 2^NUM_W (Newton steps, 3 -> 24 bits).
    function automatic t_inv_tab build_inv_tab();
        t_inv_tab          tab;
        logic [NUM_W-1:0]  f;
        logic [NUM_W-1:0]  x;
        logic [NUM_W-1:0]  fx;
        for (int k = 0; k < INV_N; k++) begin
            f = NUM_W'(2 * k + 1);
            x = f;
            for (int m = 0; m < 3; m++) begin
                fx = NUM_W'(f * x);
                x  = NUM_W'(x * NUM_W'(NUM_W'(2) - fx));
            end
            tab[k] = x;
        end
        return tab;
    endfunction

    localparam t_inv_tab INV_TAB = build_inv_tab();

endpackage

/* design/prime_factorizer_spf_sieve_unit.sv */
// Top level: SPF table build after reset and query factorization by table walk.
//
//  channel   direction  handshake          payload
//  query     in         i_valid / o_ready  i_number
//  result    out        o_valid / i_ready  o_factor, o_last, o_none
//
// After reset the table is cleared, then sieved: a read and check per candidate i
// below sqrt(LIMIT) and a read and conditional write per multiple visited;
// o_ready stays low until it is done.
// A query does a table read, lookup and divide per prime factor; a query of 0,
// 1 or at least LIMIT gives a single none result.
// Output register stalls hold the divide step; one query is in flight at a time.
module prime_factorizer_spf_sieve_unit
    import pfs_pkg::*;
#(
    parameter int LIMIT = LIMIT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [NUM_W-1:0] i_number,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [NUM_W-1:0] o_factor,
    output logic             o_last,
    output logic             o_none
);

    localparam int AW = $clog2(LIMIT);
    localparam int IW = (AW + 1) / 2 + 1;
    localparam int SW = 2 * IW;
    localparam int JW = AW + 1;

    logic [ENTRY_W-1:0] r_mem [LIMIT];
    logic [ENTRY_W-1:0] r_rdata;

    t_state             r_state;
    t_state             n_state;
    logic [IW-1:0]      r_i;
    logic [JW-1:0]      r_j;
    logic [NUM_W-1:0]   r_rem;
    logic               r_tbl_ready;
    logic               r_o_valid;
    logic [NUM_W-1:0]   r_o_factor;
    logic               r_o_last;
    logic               r_o_none;

    logic [SW-1:0]      w_sq;
    logic [JW-1:0]      w_jn;
    logic               w_sq_done;
    logic               w_j_done;
    logic               w_bad_num;
    logic               w_accept;
    logic               w_slot_free;
    logic               w_emit;
    logic               w_emit_none;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    logic [ENTRY_W-1:0] w_mem_wdata;
    logic               w_mem_re;
    logic [AW-1:0]      w_mem_raddr;
    logic               w_fac_load;
    logic [NUM_W-1:0]   w_fac;
    logic [NUM_W-1:0]   w_quot;
    logic               w_quot_end;

    assign w_sq        = SW'(r_i) * SW'(r_i);
    assign w_sq_done   = (w_sq >= SW'(LIMIT));
    assign w_jn        = r_j + JW'(r_i);
    assign w_j_done    = (w_jn >= JW'(LIMIT));
    assign w_bad_num   = (i_number < NUM_W'(2)) || ({1'b0, i_number} >= (NUM_W + 1)'(LIMIT));
    assign w_slot_free = !r_o_valid || i_ready;
    assign w_accept    = i_valid && o_ready;
    assign w_quot_end  = (w_quot <= NUM_W'(1));

    pfs_xdiv u_xdiv (
        .i_clk   (i_clk),
        .i_load  (w_fac_load),
        .i_rem   (r_rem),
        .i_entry (r_rdata),
        .o_fac   (w_fac),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_mem[w_mem_raddr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_j == JW'(LIMIT - 1)) n_state = S_SV_RDI;
            end
            S_SV_RDI: begin
                n_state = w_sq_done ? S_IDLE : S_SV_CHKI;
            end
            S_SV_CHKI: begin
                n_state = (r_rdata == '0) ? S_SV_RDJ : S_SV_RDI;
            end
            S_SV_RDJ: begin
                n_state = S_SV_CHKJ;
            end
            S_SV_CHKJ: begin
                n_state = w_j_done ? S_SV_RDI : S_SV_RDJ;
            end
            S_IDLE: begin
                if (i_valid) n_state = w_bad_num ? S_Q_NONE : S_Q_RD;
            end
            S_Q_RD: begin
                n_state = S_Q_LOOK;
            end
            S_Q_LOOK: begin
                n_state = S_Q_DIV;
            end
            S_Q_DIV: begin
                if (w_slot_free) n_state = w_quot_end ? S_IDLE : S_Q_RD;
            end
            S_Q_NONE: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_j[AW-1:0];
        w_mem_wdata = '0;
        w_mem_re    = 1'b0;
        w_mem_raddr = r_rem[AW-1:0];
        w_fac_load  = 1'b0;
        w_emit      = 1'b0;
        w_emit_none = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_mem_we = 1'b1;
            end
            S_SV_RDI: begin
                w_mem_re    = !w_sq_done;
                w_mem_raddr = AW'(r_i);
            end
            S_SV_CHKI: ;
            S_SV_RDJ: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = r_j[AW-1:0];
            end
            S_SV_CHKJ: begin
                w_mem_we    = (r_rdata == '0);
                w_mem_wdata = ENTRY_W'(r_i);
            end
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_Q_RD: begin
                w_mem_re = 1'b1;
            end
            S_Q_LOOK: begin
                w_fac_load = 1'b1;
            end
            S_Q_DIV: begin
                w_emit = w_slot_free;
            end
            S_Q_NONE: begin
                w_emit_none = w_slot_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_i         <= '0;
            r_j         <= '0;
            r_rem       <= '0;
            r_tbl_ready <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: begin
                    r_j <= r_j + JW'(1);
                    r_i <= IW'(2);
                end
                S_SV_RDI: begin
                    r_j <= JW'(w_sq);
                    if (w_sq_done) r_tbl_ready <= 1'b1;
                end
                S_SV_CHKI: begin
                    if (r_rdata != '0) r_i <= r_i + IW'(1);
                end
                S_SV_CHKJ: begin
                    r_j <= w_jn;
                    if (w_j_done) r_i <= r_i + IW'(1);
                end
                S_IDLE: begin
                    if (w_accept) r_rem <= w_bad_num ? '0 : i_number;
                end
                S_Q_DIV: begin
                    if (w_slot_free) r_rem <= w_quot;
                end
                default: ;
            endcase
            if (w_emit || w_emit_none) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_factor <= w_fac;
            r_o_last   <= w_quot_end;
            r_o_none   <= 1'b0;
        end else if (w_emit_none) begin
            r_o_factor <= '0;
            r_o_last   <= 1'b1;
            r_o_none   <= 1'b1;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_factor = r_o_factor;
    assign o_last   = r_o_last;
    assign o_none   = r_o_none;

    a_ready_after_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_tbl_ready)
        else $error("query accepted before table build finished");

    a_no_write_after_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> !r_tbl_ready)
        else $error("table written after build finished");

    a_exact_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_DIV) |-> ((32'(w_quot) * 32'(w_fac)) == 32'(r_rem)))
        else $error("factor does not divide remainder exactly");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_none) |-> (o_last && (o_factor == '0)))
        else $error("none result not marked last with zero factor");

endmodule

/* design/pfs_xdiv.sv */
// Exact division by smallest prime factor: 1 if prime, shift for 2, else inverse.
module pfs_xdiv
    import pfs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [NUM_W-1:0]   i_rem,
    input  logic [ENTRY_W-1:0] i_entry,
    output logic [NUM_W-1:0]   o_fac,
    output logic [NUM_W-1:0]   o_quot
);

    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_fac;
    logic [NUM_W-1:0] r_inv;
    t_dmode           r_mode;
    logic [NUM_W-1:0] w_prod;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_rem;
            r_inv <= INV_TAB[i_entry[ENTRY_W-1:1]];
            if (i_entry == '0) begin
                r_fac  <= i_rem;
                r_mode <= DM_PRIME;
            end else if (i_entry == ENTRY_W'(2)) begin
                r_fac  <= NUM_W'(i_entry);
                r_mode <= DM_HALF;
            end else begin
                r_fac  <= NUM_W'(i_entry);
                r_mode <= DM_ODD;
            end
        end
    end

    assign w_prod = NUM_W'(r_rem * r_inv);

    always_comb begin
        unique case (r_mode)
            DM_PRIME: o_quot = NUM_W'(1);
            DM_HALF:  o_quot = {1'b0, r_rem[NUM_W-1:1]};
            DM_ODD:   o_quot = w_prod;
            default:  o_quot = w_prod;
        endcase
    end

    assign o_fac = r_fac;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the SPF sieve factorizer: queued stimulus, clocked driver and monitor.
module tb;
    import pfs_pkg::*;

    localparam int N_RAND    = 450;
    localparam int HOLD_LEN  = 400;
    localparam int HOLD_AT   = 200;
    localparam int DRAIN_CYC = 64;
    localparam int MAX_FACS  = 15;

    typedef struct packed {
        logic [NUM_W-1:0] factor;
        logic             last;
        logic             none;
    } t_fac_res;

    logic             i_clk    = 1'b0;
    logic             i_rst_n  = 1'b0;
    logic             i_valid  = 1'b0;
    logic [NUM_W-1:0] i_number = '0;
    logic             i_ready  = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [NUM_W-1:0] o_factor;
    logic             o_last;
    logic             o_none;

    logic [ENTRY_W-1:0] spf_tab [0:LIMIT_DEF-1];
    logic [NUM_W-1:0]   number_q [$];
    t_fac_res           factors_q [$];

    int  n_queries  = 0;
    int  n_accepted = 0;
    int  err_cnt    = 0;
    bit  in_taken   = 1'b0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    prime_factorizer_spf_sieve_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_number (i_number),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_factor (o_factor),
        .o_last   (o_last),
        .o_none   (o_none)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic build_spf_table();
        for (int k = 0; k < LIMIT_DEF; k++) spf_tab[k] = '0;
        for (int p = 2; p * p < LIMIT_DEF; p++) begin
            if (spf_tab[p] == '0) begin
                for (int m = p * p; m < LIMIT_DEF; m += p) begin
                    if (spf_tab[m] == '0) spf_tab[m] = ENTRY_W'(p);
                end
            end
        end
    endtask

    task automatic predict_factors(input logic [NUM_W-1:0] num);
        t_fac_res res;
        int       rem;
        int       f;
        int       cnt;
        rem = int'(num);
        cnt = 0;
        if (rem < 2 || rem >= LIMIT_DEF) begin
            res.factor = '0;
            res.last   = 1'b1;
            res.none   = 1'b1;
            factors_q  = {factors_q, res};
        end else begin
            while (rem > 1 && cnt < MAX_FACS) begin
                f = int'(spf_tab[rem]);
                if (f == 0) f = rem;
                rem = rem / f;
                res.factor = NUM_W'(f);
                res.last   = (rem <= 1);
                res.none   = 1'b0;
                factors_q  = {factors_q, res};
                cnt++;
            end
        end
    endtask

    function automatic logic [NUM_W-1:0] rand_number();
        int v;
        int p;
        int primes [6] = '{2, 3, 5, 7, 11, 13};
        case ($urandom_range(9))
            5: v = $urandom_range(300);
            6: begin
                v = 1;
                p = primes[$urandom_range(5)];
                while (v * p < LIMIT_DEF && $urandom_range(7) != 0) begin
                    v = v * p;
                    p = primes[$urandom_range(5)];
                end
            end
            7: v = 1 << $urandom_range(15);
            8: begin
                p = $urandom_range(255, 2);
                v = p * p;
            end
            9: v = ($urandom_range(1) != 0) ? $urandom_range(1) : 65535 - $urandom_range(15);
            default: v = $urandom_range(65535);
        endcase
        return NUM_W'(v);
    endfunction

    // input transfers, predictions and result checks
    always @(posedge i_clk) begin
        t_fac_res got;
        t_fac_res want;
        in_taken = i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_factors(i_number);
                n_accepted <= n_accepted + 1;
            end
            if (o_valid && i_ready) begin
                got.factor = o_factor;
                got.last   = o_last;
                got.none   = o_none;
                if (factors_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: unexpected result factor=%0d last=%0b none=%0b",
                                 got.factor, got.last, got.none);
                end else begin
                    want = factors_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("ERROR: exp %0d/%0b/%0b, got %0d/%0b/%0b",
                                     want.factor, want.last, want.none,
                                     got.factor, got.last, got.none);
                    end
                end
            end
        end
    end

    // query driver
    always @(negedge i_clk) begin
        int idle_pct;
        idle_pct = (n_accepted < 160) ? 12 : (n_accepted < 320) ? 51 : 0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (number_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_valid  <= 1'b1;
                i_number <= number_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver with one long hold-off
    always @(negedge i_clk) begin
        int idle_pct;
        idle_pct = (n_accepted < 160) ? 51 : (n_accepted < 320) ? 12 : 0;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin
        int directed [22] = '{0, 1, 2, 3, 4, 6, 9, 25, 65535, 65521, 32768, 49152,
                              65534, 65025, 63001, 1024, 30030, 251, 257, 43690,
                              21845, 65280};
        build_spf_table();
        foreach (directed[k]) number_q = {number_q, NUM_W'(directed[k])};
        for (int k = 0; k < N_RAND; k++) number_q = {number_q, rand_number()};
        n_queries = number_q.size();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (n_accepted != n_queries) @(posedge i_clk);
        while (factors_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0 && factors_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #36000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
